### rtl/core/kbr_pkg.sv
package kbr_pkg;

	// configuration register width and indexes
	localparam int REG_W = 12;
	localparam int CFG_ADDR_W = 2;

	localparam logic [CFG_ADDR_W-1:0] CFG_ACK_DELAY    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_ACK_PULSE    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_TIMEOUT = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_PULSE   = 2'd3;

	// register values after reset
	localparam logic [REG_W-1:0] ACK_DELAY_RST    = 12'd120;
	localparam logic [REG_W-1:0] ACK_PULSE_RST    = 12'd170;
	localparam logic [REG_W-1:0] SYNC_TIMEOUT_RST = 12'd300;
	localparam logic [REG_W-1:0] SYNC_PULSE_RST   = 12'd20;

	// default tick counter width
	localparam int TICK_COUNT_WIDTH_DEF = 12;

	// stream word widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int BYTE_W      = 8;
	localparam int BITCNT_W    = 4;

	// phase codes
	localparam int PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PH_NORMAL    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_ACK_WAIT  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_ACK_PULSE = 2'd2;
	localparam logic [PHASE_W-1:0] PH_SYNC      = 2'd3;

	localparam logic [BITCNT_W-1:0] BITCNT_MAX  = 4'd15;
	localparam logic [BITCNT_W-1:0] BITCNT_LAST = 4'd7;

endpackage

### rtl/core/keyboard_serial_byte_receiver.sv
// Keyboard serial byte receiver.
// Input stream (s_axis): one word per timer tick with the sampled keyboard
// clock and data line levels. Output stream (m_axis): one word per input
// word with the data line pull-low request and, when a byte completed on that
// tick, the byte (tuser high). The byte is 0 when tuser is low.
// A frame starts when the data line goes high while idle; bits arrive LSB
// first on rising clock edges. The eighth bit reports the byte on that tick,
// then the block waits ack_delay_ticks, pulls data low for ack_pulse_ticks
// and returns to idle. With no clock change for sync_timeout_ticks during a
// frame it pulls data low for sync_pulse_ticks instead.
// The result word is registered: it appears in the cycle after its input word is taken.
// Throughput: one word per cycle while m_axis_tready does not stall the output;
// the tick state update is a single level of edge detect, compare and increment logic ahead of the state registers.
// Reset (arst_n low) restores the default tick settings, clears the receive
// state and empties the output register.
// When m_axis_tready is low with a word held, s_axis_tready drops; it rises
// again in the cycle the held word is taken.
// Config writes (cfg_we) are taken at once; make them only while idle.
module keyboard_serial_byte_receiver #(
	parameter int TICK_COUNT_WIDTH = kbr_pkg::TICK_COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [kbr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [kbr_pkg::REG_W-1:0]           cfg_wdata,
	// tick input
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [kbr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [0] clock_level, [1] data_level
	// result output
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [kbr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [0] data_drive_low,
	                                                           // [8:1] received_byte
	output logic                                m_axis_tuser   // [0] byte_valid
);

	localparam int TW = TICK_COUNT_WIDTH;
	localparam int CW = (TW > kbr_pkg::REG_W) ? TW : kbr_pkg::REG_W;
	localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

	// settings clamped to the tick counter range
	function automatic logic [TW-1:0] clamp_ticks(input logic [kbr_pkg::REG_W-1:0] v);
		logic [CW-1:0] ext;
		ext = CW'(v);
		if (ext > CW'(TICK_MAX))
			return TICK_MAX;
		else
			return TW'(ext);
	endfunction

	// config registers
	logic [kbr_pkg::REG_W-1:0] ack_delay_q, ack_pulse_q, sync_timeout_q, sync_pulse_q;

	// receive state
	logic                            clock_prev_q, data_prev_q, frame_active_q;
	logic [TW-1:0]                   elapsed_q, phase_ticks_q;
	logic [kbr_pkg::BYTE_W-1:0]      shift_q;
	logic [kbr_pkg::BITCNT_W-1:0]    bit_count_q;
	logic [kbr_pkg::PHASE_W-1:0]     phase_q;

	// next state
	logic                            clock_prev_d, data_prev_d, frame_active_d;
	logic [TW-1:0]                   elapsed_d, phase_ticks_d;
	logic [kbr_pkg::BYTE_W-1:0]      shift_d;
	logic [kbr_pkg::BITCNT_W-1:0]    bit_count_d;
	logic [kbr_pkg::PHASE_W-1:0]     phase_d;
	logic                            drive_d, valid_d;
	logic [kbr_pkg::BYTE_W-1:0]      byte_d;

	// output register
	logic                            out_valid_q;
	logic                            out_drive_q, out_bvalid_q;
	logic [kbr_pkg::BYTE_W-1:0]      out_byte_q;

	logic in_clk, in_dat, in_acc, started;
	logic [TW-1:0] ack_delay_c, ack_pulse_c, sync_timeout_c, sync_pulse_c, pulse_len;

	assign in_clk = s_axis_tdata[0];
	assign in_dat = s_axis_tdata[1];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	assign ack_delay_c    = clamp_ticks(ack_delay_q);
	assign ack_pulse_c    = clamp_ticks(ack_pulse_q);
	assign sync_timeout_c = clamp_ticks(sync_timeout_q);
	assign sync_pulse_c   = clamp_ticks(sync_pulse_q);
	assign pulse_len = (phase_q == kbr_pkg::PH_SYNC) ? sync_pulse_c : ack_pulse_c;

	// data going high while idle opens a frame and does nothing else that tick
	assign started = (in_dat != data_prev_q) && !frame_active_q && in_dat;

	always_comb begin
		clock_prev_d   = clock_prev_q;
		data_prev_d    = data_prev_q;
		frame_active_d = frame_active_q;
		elapsed_d      = elapsed_q;
		phase_ticks_d  = phase_ticks_q;
		shift_d        = shift_q;
		bit_count_d    = bit_count_q;
		phase_d        = phase_q;
		drive_d        = 1'b0;
		valid_d        = 1'b0;
		byte_d         = '0;
		unique case (phase_q)
			kbr_pkg::PH_ACK_WAIT: begin
				if (phase_ticks_q < ack_delay_c) begin
					phase_ticks_d = phase_ticks_q + 1'b1;
				end else begin
					phase_d       = kbr_pkg::PH_ACK_PULSE;
					phase_ticks_d = TW'(1);
					drive_d       = 1'b1;
				end
			end
			kbr_pkg::PH_ACK_PULSE, kbr_pkg::PH_SYNC: begin
				// ending tick releases the line and only returns to sampling
				if (phase_ticks_q < pulse_len) begin
					phase_ticks_d = phase_ticks_q + 1'b1;
					drive_d       = 1'b1;
				end else begin
					phase_d       = kbr_pkg::PH_NORMAL;
					phase_ticks_d = '0;
				end
			end
			default: begin
				if ((in_dat != data_prev_q) && !frame_active_q)
					data_prev_d = in_dat;
				if (started) begin
					frame_active_d = 1'b1;
					elapsed_d      = '0;
					shift_d        = '0;
					bit_count_d    = '0;
				end else if (in_clk != clock_prev_q) begin
					clock_prev_d = in_clk;
					if (in_clk) begin
						frame_active_d = 1'b1;
						elapsed_d      = '0;
						shift_d        = {in_dat, shift_q[kbr_pkg::BYTE_W-1:1]};
						if (bit_count_q != kbr_pkg::BITCNT_MAX)
							bit_count_d = bit_count_q + 1'b1;
						if (bit_count_q == kbr_pkg::BITCNT_LAST) begin
							valid_d        = 1'b1;
							byte_d         = shift_d;
							frame_active_d = 1'b0;
							phase_d        = kbr_pkg::PH_ACK_WAIT;
							phase_ticks_d  = '0;
						end
					end
				end else if (frame_active_q) begin
					if (elapsed_q >= sync_timeout_c) begin
						frame_active_d = 1'b0;
						elapsed_d      = '0;
						phase_d        = kbr_pkg::PH_SYNC;
						phase_ticks_d  = TW'(1);
						drive_d        = 1'b1;
					end else begin
						elapsed_d = elapsed_q + 1'b1;
					end
				end
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_delay_q    <= kbr_pkg::ACK_DELAY_RST;
			ack_pulse_q    <= kbr_pkg::ACK_PULSE_RST;
			sync_timeout_q <= kbr_pkg::SYNC_TIMEOUT_RST;
			sync_pulse_q   <= kbr_pkg::SYNC_PULSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				kbr_pkg::CFG_ACK_DELAY:    ack_delay_q    <= cfg_wdata;
				kbr_pkg::CFG_ACK_PULSE:    ack_pulse_q    <= cfg_wdata;
				kbr_pkg::CFG_SYNC_TIMEOUT: sync_timeout_q <= cfg_wdata;
				default:                   sync_pulse_q   <= cfg_wdata;
			endcase
		end
	end

	// receive state, advanced once per accepted tick word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_prev_q   <= 1'b0;
			data_prev_q    <= 1'b0;
			frame_active_q <= 1'b0;
			elapsed_q      <= '0;
			phase_ticks_q  <= '0;
			shift_q        <= '0;
			bit_count_q    <= '0;
			phase_q        <= kbr_pkg::PH_NORMAL;
		end else if (in_acc) begin
			clock_prev_q   <= clock_prev_d;
			data_prev_q    <= data_prev_d;
			frame_active_q <= frame_active_d;
			elapsed_q      <= elapsed_d;
			phase_ticks_q  <= phase_ticks_d;
			shift_q        <= shift_d;
			bit_count_q    <= bit_count_d;
			phase_q        <= phase_d;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s_axis_tready)
			out_valid_q <= s_axis_tvalid;
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_drive_q  <= drive_d;
			out_bvalid_q <= valid_d;
			out_byte_q   <= byte_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(kbr_pkg::OUT_TDATA_W - kbr_pkg::BYTE_W - 1){1'b0}},
	                        out_byte_q, out_drive_q};
	assign m_axis_tuser  = out_bvalid_q;

	// a byte report never pulls the line low on the same tick
	a_byte_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
		else $error("byte report with data drive");

	// outside normal sampling no frame is open
	a_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != kbr_pkg::PH_NORMAL |-> !frame_active_q)
		else $error("frame open during ack or sync");

	// a reported byte always leads into the acknowledge wait
	a_byte_ack: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && valid_d |=> phase_q == kbr_pkg::PH_ACK_WAIT && phase_ticks_q == '0)
		else $error("byte without ack wait");

	// a pulse phase always holds a started pulse count
	a_pulse_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == kbr_pkg::PH_SYNC || phase_q == kbr_pkg::PH_ACK_PULSE)
		|-> phase_ticks_q != '0)
		else $error("pulse counter lost");

endmodule

### tb/tb_keyboard_serial_byte_receiver.sv
module tb_keyboard_serial_byte_receiver;

	// one result word: data pull-low request, byte strobe and the byte
	typedef struct packed {
		logic       drive_low;
		logic       byte_valid;
		logic [7:0] rx_byte;
	} kbd_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            cfg_we = 1'b0;
	logic [kbr_pkg::CFG_ADDR_W-1:0]  cfg_addr = kbr_pkg::CFG_ACK_DELAY;
	logic [kbr_pkg::REG_W-1:0]       cfg_wdata = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [kbr_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] clock_level, [1] data_level
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [kbr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // [0] data_drive_low, [8:1] received_byte
	logic                            m_axis_tuser;        // [0] byte_valid

	keyboard_serial_byte_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// Line model: tick settings and receive state, reset values
	// ---------------------------------------------------------------
	logic [kbr_pkg::REG_W-1:0]    ack_delay    = kbr_pkg::ACK_DELAY_RST;
	logic [kbr_pkg::REG_W-1:0]    ack_pulse    = kbr_pkg::ACK_PULSE_RST;
	logic [kbr_pkg::REG_W-1:0]    sync_timeout = kbr_pkg::SYNC_TIMEOUT_RST;
	logic [kbr_pkg::REG_W-1:0]    sync_pulse   = kbr_pkg::SYNC_PULSE_RST;

	logic                         kb_clk_prev  = 1'b0;
	logic                         kb_dat_prev  = 1'b0;
	logic                         in_frame     = 1'b0;
	logic [kbr_pkg::REG_W-1:0]    idle_ticks   = '0;
	logic [7:0]                   shifter      = '0;
	logic [kbr_pkg::BITCNT_W-1:0] bits_seen    = '0;
	logic [kbr_pkg::PHASE_W-1:0]  line_phase   = kbr_pkg::PH_NORMAL;
	logic [kbr_pkg::REG_W-1:0]    phase_count  = '0;

	kbd_result_t pending_results[$];   // results owed by the block, oldest first
	logic [1:0]  line_samples[$];      // {data, clock} per tick, waiting to be sent

	int queued_cnt = 0;   // words pushed toward the block
	int live_cnt   = 0;   // of those, words the block actually samples
	int seen_cnt   = 0;   // result words taken
	int fail_cnt   = 0;
	int cyc_cnt    = 0;
	int hold_left  = 0;
	bit held_once  = 1'b0;

	// periodic window where neither side idles
	wire calm = (cyc_cnt % 1600) >= 1200;

	// Pull-low pulse tick: drive while the count runs, release on the last tick.
	// Limits are 12-bit registers, so the clamp to the tick counter max is a no-op.
	function automatic logic pulse_step(input logic [kbr_pkg::REG_W-1:0] len);
		if (phase_count < len) begin
			phase_count++;
			return 1'b1;
		end
		line_phase = kbr_pkg::PH_NORMAL;
		phase_count = '0;
		return 1'b0;
	endfunction

	// Advance the line model by one tick and return the word it owes.
	function automatic kbd_result_t line_tick(input logic clk_lv, input logic dat_lv);
		kbd_result_t r;
		logic started;
		r = '0;
		started = 1'b0;
		unique case (line_phase)
			kbr_pkg::PH_ACK_WAIT: begin
				if (phase_count < ack_delay) begin
					phase_count++;
				end else begin
					line_phase = kbr_pkg::PH_ACK_PULSE;
					phase_count = kbr_pkg::REG_W'(1);
					r.drive_low = 1'b1;
				end
			end
			kbr_pkg::PH_ACK_PULSE: r.drive_low = pulse_step(ack_pulse);
			kbr_pkg::PH_SYNC:      r.drive_low = pulse_step(sync_pulse);
			default: begin
				// data edges only matter while idle; a rising one opens a frame
				if (dat_lv != kb_dat_prev && !in_frame) begin
					kb_dat_prev = dat_lv;
					if (dat_lv) begin
						in_frame = 1'b1;
						idle_ticks = '0;
						shifter = '0;
						bits_seen = '0;
						started = 1'b1;
					end
				end
				// the start tick does nothing else
				if (!started) begin
					if (clk_lv != kb_clk_prev) begin
						kb_clk_prev = clk_lv;
						if (clk_lv) begin
							// rising edge shifts even with no frame open
							in_frame = 1'b1;
							idle_ticks = '0;
							shifter = {dat_lv, shifter[7:1]};
							if (bits_seen < kbr_pkg::BITCNT_MAX)
								bits_seen++;
							if (bits_seen == kbr_pkg::BITCNT_LAST + 1) begin
								r.byte_valid = 1'b1;
								r.rx_byte = shifter;
								in_frame = 1'b0;
								line_phase = kbr_pkg::PH_ACK_WAIT;
								phase_count = '0;
							end
						end
					end else if (in_frame) begin
						if (idle_ticks >= sync_timeout) begin
							in_frame = 1'b0;
							idle_ticks = '0;
							line_phase = kbr_pkg::PH_SYNC;
							phase_count = kbr_pkg::REG_W'(1);
							r.drive_low = 1'b1;
						end else begin
							idle_ticks++;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk)
		cyc_cnt <= cyc_cnt + 1;

	// ---------------------------------------------------------------
	// Tick driver: takes line samples off the queue, predicts on accept
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : tick_driver
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(line_tick(s_axis_tdata[0], s_axis_tdata[1]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (line_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= kbr_pkg::IN_TDATA_W'(line_samples.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_check
		kbd_result_t want;
		kbd_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.drive_low = m_axis_tdata[0];
			got.rx_byte = m_axis_tdata[8:1];
			got.byte_valid = m_axis_tuser;
			seen_cnt++;
			if (pending_results.size() == 0) begin
				$display("%0t: word with none owed: drive_low %0b valid %0b byte %02h",
					$time, got.drive_low, got.byte_valid, got.rx_byte);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (got.drive_low !== want.drive_low) begin
					$display("%0t: drive_low expected %0b got %0b",
						$time, want.drive_low, got.drive_low);
					fail_cnt++;
				end
				if (got.byte_valid !== want.byte_valid) begin
					$display("%0t: byte_valid expected %0b got %0b",
						$time, want.byte_valid, got.byte_valid);
					fail_cnt++;
				end
				if (got.rx_byte !== want.rx_byte) begin
					$display("%0t: received_byte expected %02h got %02h",
						$time, want.rx_byte, got.rx_byte);
					fail_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : sink_ready
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			// one long hold-off while the sender keeps offering: block must back up
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!held_once && seen_cnt >= 420) begin
				held_once <= 1'b1;
				hold_left <= 400;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	logic gen_clk = 1'b0;
	logic gen_dat = 1'b0;

	// live ticks count toward the stimulus length; filler during pulses does not
	task automatic push_tick(input logic c, input logic d, input bit live = 1'b1);
		line_samples.push_back({d, c});
		queued_cnt++;
		if (live)
			live_cnt++;
		gen_clk = c;
		gen_dat = d;
	endtask

	// random words while the block ignores its input
	task automatic filler(input int n);
		repeat (n) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
	endtask

	// One frame: data low, data rising (start), then nbits LSB-first bits on
	// rising clock edges. Fewer than eight bits leaves the frame to time out.
	task automatic send_frame(input logic [7:0] b, input int nbits, input int gap_hi,
		input bit edge_on_start);
		push_tick(1'b0, 1'b0);
		push_tick(edge_on_start, 1'b1);
		for (int i = 0; i < nbits; i++) begin
			// a clock already high on the start tick rises on the next tick
			if (!(i == 0 && edge_on_start))
				repeat ($urandom_range(1, gap_hi)) push_tick(1'b0, b[i]);
			push_tick(1'b1, b[i]);
			repeat ($urandom_range(0, gap_hi - 1)) push_tick(1'b1, b[i]);
		end
		if (nbits == 8) begin
			filler(ack_delay + ack_pulse + 3);
		end else begin
			repeat (sync_timeout + 2) push_tick(gen_clk, gen_dat);
			filler(sync_pulse + 3);
		end
	endtask

	task automatic random_traffic(input int budget);
		int stop_at;
		int pick;
		int gap_hi;
		bit short_to;
		stop_at = live_cnt + budget;
		short_to = sync_timeout <= 64;
		// keep clock gaps inside the timeout for well-formed frames
		gap_hi = sync_timeout >= 8 ? 4 : (sync_timeout >= 2 ? sync_timeout / 2 : 1);
		while (live_cnt < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 72 || !short_to) begin
				send_frame(8'($urandom), 8, gap_hi, $urandom_range(0, 9) == 0);
			end else if (pick < 82) begin
				send_frame(8'($urandom), $urandom_range(0, 7), gap_hi, 1'b0);
			end else if (pick < 89) begin
				// clock gap longer than the timeout somewhere in the frame
				send_frame(8'($urandom), 8, sync_timeout + 3, 1'b0);
			end else begin
				repeat ($urandom_range(4, 24))
					push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// wait for every owed word, then let the output register empty
	task automatic settle();
		while (seen_cnt != queued_cnt)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [kbr_pkg::CFG_ADDR_W-1:0] idx,
		input logic [kbr_pkg::REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		unique case (idx)
			kbr_pkg::CFG_ACK_DELAY:    ack_delay = val;
			kbr_pkg::CFG_ACK_PULSE:    ack_pulse = val;
			kbr_pkg::CFG_SYNC_TIMEOUT: sync_timeout = val;
			default:                   sync_pulse = val;
		endcase
	endtask

	task automatic set_timing(input int d, input int ap, input int st, input int sp);
		write_reg(kbr_pkg::CFG_ACK_DELAY, kbr_pkg::REG_W'(d));
		write_reg(kbr_pkg::CFG_ACK_PULSE, kbr_pkg::REG_W'(ap));
		write_reg(kbr_pkg::CFG_SYNC_TIMEOUT, kbr_pkg::REG_W'(st));
		write_reg(kbr_pkg::CFG_SYNC_PULSE, kbr_pkg::REG_W'(sp));
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset timing: all-zero byte with the clock high on the start tick
		send_frame(8'h00, 8, 1, 1'b1);
		settle();

		// short timing for the directed corner cases
		set_timing(5, 3, 12, 4);
		// data falls while idle, then rising edges with no frame: the bit count
		// climbs past eight to saturation without a report, then times out
		push_tick(1'b0, 1'b0);
		repeat (9) begin
			push_tick(1'b1, 1'b0);
			push_tick(1'b0, 1'b0);
		end
		repeat (sync_timeout + 2) push_tick(1'b0, 1'b0);
		filler(sync_pulse + 3);
		send_frame(8'h5A, 3, 2, 1'b0);
		settle();

		// zero-length pulses, longest timeout
		set_timing(0, 0, 4095, 0);
		random_traffic(150);
		settle();

		// moderate waits and pulses, timeout of 1: kept to a few frames
		set_timing(20, 30, 1, 25);
		send_frame(8'h81, 8, 1, 1'b0);
		send_frame(8'h7E, 8, 1, 1'b1);
		send_frame(8'h3C, 2, 1, 1'b0);
		settle();

		repeat (6) begin
			set_timing($urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 24), $urandom_range(0, 15));
			random_traffic(70);
			settle();
		end

		// zero timeout: any quiet tick in a frame triggers a sync pulse
		set_timing(7, 1, 0, 1);
		random_traffic(40);
		settle();

		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#200000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
